@@ hw/rtl/assert_macros.svh @@
// Assertion helpers for the RTL of the timer list.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every rising clock edge outside reset.
`define DOTL_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Implication checked in the same cycle.
`define DOTL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/dotl_pkg.sv @@
// ---------------------------------------------------------------------------
// dotl_pkg
// Types and codes of the deadline ordered timer list.
// ---------------------------------------------------------------------------
package dotl_pkg;

	localparam int IV_BITS = 31;

	localparam logic [1:0] CMD_START   = 2'd0;
	localparam logic [1:0] CMD_STOP    = 2'd1;
	localparam logic [1:0] CMD_RESTART = 2'd2;
	localparam logic [1:0] CMD_TICK    = 2'd3;

	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_EXPIRY = 1'b1;

	localparam logic STATUS_OK          = 1'b0;
	localparam logic STATUS_NOT_RUNNING = 1'b1;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [3:0]         timer_id;
		logic [IV_BITS-1:0] interval_ms;
		logic               repeat_req;
	} in_item_t;

	typedef struct packed {
		logic       kind;
		logic       status;
		logic [3:0] fired_id;
		logic       last;
	} out_item_t;

	// Results of the deadline compare for one list entry.
	typedef struct packed {
		logic ins_here;
		logic expired;
	} cmp_res_t;

endpackage

@@ hw/rtl/dotl_ram.sv @@
// ---------------------------------------------------------------------------
// dotl_ram
// Simple dual port RAM with one write port and one registered read port.
// ---------------------------------------------------------------------------
module dotl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

@@ hw/rtl/dotl_time_cmp.sv @@
// ---------------------------------------------------------------------------
// dotl_time_cmp
// Remaining time and expiry test of one list entry against the current time.
// ---------------------------------------------------------------------------
module dotl_time_cmp #(
	parameter int TIME_BITS = 32
) (
	input  logic [TIME_BITS-1:0]       now,
	input  logic [TIME_BITS-1:0]       label,
	input  logic [dotl_pkg::IV_BITS-1:0] slot_iv,
	input  logic [dotl_pkg::IV_BITS-1:0] ins_iv,
	output dotl_pkg::cmp_res_t         res
);
	import dotl_pkg::*;

	localparam int CW = (TIME_BITS > IV_BITS) ? TIME_BITS : IV_BITS;
	localparam logic [TIME_BITS-1:0] HALF_LIM = {1'b0, {(TIME_BITS-1){1'b1}}};

	logic [TIME_BITS-1:0] remain;
	logic [TIME_BITS-1:0] elapsed;

	// All differences wrap modulo the width of the time counter.
	assign remain  = label + TIME_BITS'(slot_iv) - now;
	assign elapsed = now - label;

	assign res.ins_here = (remain < HALF_LIM) && (CW'(remain) >= CW'(ins_iv));
	assign res.expired  = !(CW'(elapsed) < CW'(slot_iv));
endmodule

@@ hw/rtl/deadline_ordered_timer_list.sv @@
// ---------------------------------------------------------------------------
// deadline_ordered_timer_list
// Software timers kept in one list ordered by deadline.
// ---------------------------------------------------------------------------
// The block takes commands on the in channel (start, stop, restart, tick) and
// returns results on the out channel. A command gives one status result; a
// tick gives one expiry report per expired timer, in list order, the final
// one with last set, and no result when nothing expires.
// Slot data sits in one RAM, the list order as next links in a second RAM.
// One item is worked on at a time; in_ready is high only when idle. A start
// walks the list entry by entry to its insertion point; a stop walks to the
// predecessor; an expiry of a repeating timer also takes the insertion walk.
// The result goes to an output register, so the next item is taken while it
// waits. A stalled receiver holds the block only when a further result must
// be loaded. Reset clears the time, the list and all running flags at once.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module deadline_ordered_timer_list #(
	parameter int NUM_TIMERS = 16,
	parameter int TIME_BITS  = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  dotl_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output dotl_pkg::out_item_t  out_data
);
	import dotl_pkg::*;

	localparam int IDW = $clog2(NUM_TIMERS);
	localparam int LW  = $clog2(NUM_TIMERS + 1);
	localparam int DW  = 1 + IV_BITS + TIME_BITS;

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_RM       = 4'd1;
	localparam logic [3:0] ST_RM_HEAD  = 4'd2;
	localparam logic [3:0] ST_RM_WALK  = 4'd3;
	localparam logic [3:0] ST_RM_LINK  = 4'd4;
	localparam logic [3:0] ST_START    = 4'd5;
	localparam logic [3:0] ST_INS      = 4'd6;
	localparam logic [3:0] ST_INS_CMP  = 4'd7;
	localparam logic [3:0] ST_INS_LINK = 4'd8;
	localparam logic [3:0] ST_T_HEAD   = 4'd9;
	localparam logic [3:0] ST_T_CHK    = 4'd10;
	localparam logic [3:0] ST_T_FIN    = 4'd11;
	localparam logic [3:0] ST_PUSH     = 4'd12;

	logic [3:0]            state_q;
	logic [TIME_BITS-1:0]  now_q;
	logic [IDW-1:0]        head_q;
	logic [LW-1:0]         len_q;
	logic [NUM_TIMERS-1:0] running_q;
	logic [NUM_TIMERS-1:0] fired_q;
	logic [1:0]            cmd_q;
	logic [IDW-1:0]        id_q;
	logic [IV_BITS-1:0]    iv_q;
	logic                  rep_q;
	logic [IDW-1:0]        ins_id_q;
	logic [IV_BITS-1:0]    ins_iv_q;
	logic                  tick_mode_q;
	logic [IDW-1:0]        cur_q;
	logic [IDW-1:0]        prev_q;
	logic [LW-1:0]         pos_q;
	logic                  pend_valid_q;
	logic [IDW-1:0]        pend_id_q;
	out_item_t             res_q;
	logic                  out_valid_q;
	out_item_t             out_q;

	logic                  d_we, d_re, n_we, n_re;
	logic [IDW-1:0]        d_waddr, d_raddr, n_waddr, n_raddr, n_wdata;
	logic [DW-1:0]         d_wdata, d_rdata;
	logic [IDW-1:0]        n_rdata;

	logic [TIME_BITS-1:0]  rd_label;
	logic [IV_BITS-1:0]    rd_iv;
	logic                  rd_rep;
	cmp_res_t              cmp;

	logic                  accept;
	logic [IDW-1:0]        in_idx;
	logic                  in_id_ok;
	logic                  in_status;
	logic                  out_free;
	logic                  chk_fire;
	logic                  chk_stall;
	logic                  out_load;
	out_item_t             out_next;

	assign rd_label = d_rdata[TIME_BITS-1:0];
	assign rd_iv    = d_rdata[TIME_BITS+IV_BITS-1:TIME_BITS];
	assign rd_rep   = d_rdata[DW-1];

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign in_idx    = IDW'(in_data.timer_id);
	assign in_id_ok  = (32'(in_data.timer_id) < NUM_TIMERS);
	assign in_status = (!in_id_ok || ((in_data.cmd == CMD_STOP) && !running_q[in_idx])) ?
		STATUS_NOT_RUNNING : STATUS_OK;
	assign out_free  = !out_valid_q || out_ready;
	assign chk_fire  = (state_q == ST_T_CHK) && cmp.expired;
	assign chk_stall = chk_fire && pend_valid_q && !out_free;

	dotl_ram #(.WIDTH(DW), .DEPTH(NUM_TIMERS)) u_slot_ram (
		.clk   (clk),
		.we    (d_we),
		.waddr (d_waddr),
		.wdata (d_wdata),
		.re    (d_re),
		.raddr (d_raddr),
		.rdata (d_rdata)
	);

	dotl_ram #(.WIDTH(IDW), .DEPTH(NUM_TIMERS)) u_link_ram (
		.clk   (clk),
		.we    (n_we),
		.waddr (n_waddr),
		.wdata (n_wdata),
		.re    (n_re),
		.raddr (n_raddr),
		.rdata (n_rdata)
	);

	dotl_time_cmp #(.TIME_BITS(TIME_BITS)) u_cmp (
		.now     (now_q),
		.label   (rd_label),
		.slot_iv (rd_iv),
		.ins_iv  (ins_iv_q),
		.res     (cmp)
	);

	// RAM port control and output register load.
	always_comb begin
		d_we     = 1'b0;
		d_waddr  = id_q;
		d_wdata  = {rep_q, iv_q, now_q};
		d_re     = 1'b0;
		d_raddr  = head_q;
		n_we     = 1'b0;
		n_waddr  = cur_q;
		n_wdata  = ins_id_q;
		n_re     = 1'b0;
		n_raddr  = head_q;
		out_load = 1'b0;
		out_next = res_q;
		unique case (state_q)
			ST_RM: begin
				n_re    = 1'b1;
				n_raddr = (head_q == id_q) ? id_q : head_q;
			end
			ST_RM_WALK: begin
				n_re    = 1'b1;
				n_raddr = (n_rdata == id_q) ? id_q : n_rdata;
			end
			ST_RM_LINK: begin
				n_we    = 1'b1;
				n_waddr = cur_q;
				n_wdata = n_rdata;
			end
			ST_START: begin
				d_we = 1'b1;
			end
			ST_INS: begin
				d_re    = (len_q != '0);
				n_re    = (len_q != '0);
				d_raddr = head_q;
				n_raddr = head_q;
			end
			ST_INS_CMP: begin
				if (cmp.ins_here) begin
					n_we    = 1'b1;
					n_waddr = ins_id_q;
					n_wdata = cur_q;
				end else if ((pos_q + LW'(1)) == len_q) begin
					n_we    = 1'b1;
					n_waddr = cur_q;
					n_wdata = ins_id_q;
				end else begin
					d_re    = 1'b1;
					n_re    = 1'b1;
					d_raddr = n_rdata;
					n_raddr = n_rdata;
				end
			end
			ST_INS_LINK: begin
				n_we    = 1'b1;
				n_waddr = prev_q;
				n_wdata = ins_id_q;
			end
			ST_T_HEAD: begin
				if ((len_q != '0) && !fired_q[head_q]) begin
					d_re = 1'b1;
					n_re = 1'b1;
				end
			end
			ST_T_CHK: begin
				if (chk_fire && !chk_stall) begin
					if (rd_rep) begin
						d_we    = 1'b1;
						d_waddr = head_q;
						d_wdata = {rd_rep, rd_iv, now_q};
					end
					if (pend_valid_q) begin
						out_load = 1'b1;
						out_next = '{kind: KIND_EXPIRY, status: STATUS_OK,
							fired_id: 4'(pend_id_q), last: 1'b0};
					end
				end
			end
			ST_PUSH: begin
				out_load = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			now_q        <= '0;
			head_q       <= '0;
			len_q        <= '0;
			running_q    <= '0;
			fired_q      <= '0;
			cmd_q        <= CMD_START;
			id_q         <= '0;
			iv_q         <= '0;
			rep_q        <= 1'b0;
			ins_id_q     <= '0;
			ins_iv_q     <= '0;
			tick_mode_q  <= 1'b0;
			cur_q        <= '0;
			prev_q       <= '0;
			pos_q        <= '0;
			pend_valid_q <= 1'b0;
			pend_id_q    <= '0;
			res_q        <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cmd_q <= in_data.cmd;
						id_q  <= in_idx;
						iv_q  <= in_data.interval_ms;
						rep_q <= in_data.repeat_req;
						res_q <= '{kind: KIND_STATUS, status: in_status,
							fired_id: 4'd0, last: 1'b1};
						if (in_data.cmd == CMD_TICK) begin
							now_q        <= now_q + TIME_BITS'(1);
							fired_q      <= '0;
							pend_valid_q <= 1'b0;
							state_q      <= ST_T_HEAD;
						end else if (!in_id_ok) begin
							state_q <= ST_PUSH;
						end else begin
							unique case (in_data.cmd)
								CMD_START: begin
									state_q <= running_q[in_idx] ? ST_PUSH : ST_START;
								end
								CMD_STOP: begin
									state_q <= running_q[in_idx] ? ST_RM : ST_PUSH;
								end
								default: begin
									state_q <= running_q[in_idx] ? ST_RM : ST_START;
								end
							endcase
						end
					end
				end
				ST_RM: begin
					cur_q   <= head_q;
					state_q <= (head_q == id_q) ? ST_RM_HEAD : ST_RM_WALK;
				end
				ST_RM_HEAD, ST_RM_LINK: begin
					if (state_q == ST_RM_HEAD) begin
						head_q <= n_rdata;
					end
					len_q             <= len_q - LW'(1);
					running_q[id_q]   <= 1'b0;
					state_q           <= (cmd_q == CMD_RESTART) ? ST_START : ST_PUSH;
				end
				ST_RM_WALK: begin
					if (n_rdata == id_q) begin
						state_q <= ST_RM_LINK;
					end else begin
						cur_q <= n_rdata;
					end
				end
				ST_START: begin
					running_q[id_q] <= 1'b1;
					ins_id_q        <= id_q;
					ins_iv_q        <= iv_q;
					tick_mode_q     <= 1'b0;
					state_q         <= ST_INS;
				end
				ST_INS: begin
					if (len_q == '0) begin
						head_q  <= ins_id_q;
						len_q   <= LW'(1);
						state_q <= tick_mode_q ? ST_T_HEAD : ST_PUSH;
					end else begin
						cur_q   <= head_q;
						pos_q   <= '0;
						state_q <= ST_INS_CMP;
					end
				end
				ST_INS_CMP: begin
					if (cmp.ins_here) begin
						if (pos_q == '0) begin
							head_q  <= ins_id_q;
							len_q   <= len_q + LW'(1);
							state_q <= tick_mode_q ? ST_T_HEAD : ST_PUSH;
						end else begin
							state_q <= ST_INS_LINK;
						end
					end else if ((pos_q + LW'(1)) == len_q) begin
						len_q   <= len_q + LW'(1);
						state_q <= tick_mode_q ? ST_T_HEAD : ST_PUSH;
					end else begin
						prev_q <= cur_q;
						cur_q  <= n_rdata;
						pos_q  <= pos_q + LW'(1);
					end
				end
				ST_INS_LINK: begin
					len_q   <= len_q + LW'(1);
					state_q <= tick_mode_q ? ST_T_HEAD : ST_PUSH;
				end
				ST_T_HEAD: begin
					if ((len_q == '0) || fired_q[head_q]) begin
						state_q <= ST_T_FIN;
					end else begin
						state_q <= ST_T_CHK;
					end
				end
				ST_T_CHK: begin
					if (!cmp.expired) begin
						state_q <= ST_T_FIN;
					end else if (!chk_stall) begin
						// The previous expiry is now known not to be the final one.
						pend_valid_q      <= 1'b1;
						pend_id_q         <= head_q;
						fired_q[head_q]   <= 1'b1;
						head_q            <= n_rdata;
						len_q             <= len_q - LW'(1);
						if (rd_rep) begin
							ins_id_q    <= head_q;
							ins_iv_q    <= rd_iv;
							tick_mode_q <= 1'b1;
							state_q     <= ST_INS;
						end else begin
							running_q[head_q] <= 1'b0;
							state_q           <= ST_T_HEAD;
						end
					end
				end
				ST_T_FIN: begin
					if (pend_valid_q) begin
						res_q   <= '{kind: KIND_EXPIRY, status: STATUS_OK,
							fired_id: 4'(pend_id_q), last: 1'b1};
						state_q <= ST_PUSH;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_PUSH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register: a result waits here until its transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
			out_q       <= out_next;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`DOTL_ASSERT_ALWAYS(a_len_bound, clk, arst_n, len_q <= NUM_TIMERS, "list longer than slots")
	`DOTL_ASSERT_IMPL(a_len_running, clk, arst_n, state_q == ST_IDLE, $countones(running_q) == len_q, "list length differs from running count")
	`DOTL_ASSERT_IMPL(a_fire_running, clk, arst_n, chk_fire, running_q[head_q], "expiry of a timer that is not running")
endmodule
